// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers on clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// ----- sv/spk_pkg.sv -----
// ----------------------------------------------------------------------------
// Spectrum peak picker package
// Sizes, levels and the peak table types shared by the picker modules.
// ----------------------------------------------------------------------------
package spk_pkg;

    localparam int NUM_BINS  = 512;
    localparam int NUM_PEAKS = 5;

    localparam int LEVEL_W   = 16;
    localparam int BIN_W     = 9;
    localparam int WIDTH_W   = 16;
    localparam int FREQ_W    = 25;
    localparam int RANK_W    = 4;

    localparam int BIN_CNT_W = $clog2(NUM_BINS);
    localparam int RANK_CNT_W = (NUM_PEAKS > 1) ? $clog2(NUM_PEAKS) : 1;

    localparam logic signed [LEVEL_W-1:0] LEVEL_FLOOR = -16'sd25600;
    localparam logic signed [LEVEL_W-1:0] LEVEL_VALID = -16'sd25472;
    localparam logic [WIDTH_W-1:0]        BIN_WIDTH_RESET = 16'd1000;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic [BIN_W-1:0]          bin;
    } peak_t;

    typedef peak_t [NUM_PEAKS-1:0] table_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic table_t empty_table();
        table_t t;
        for (int p = 0; p < NUM_PEAKS; p++)
        begin
            t[p].level = LEVEL_FLOOR;
            t[p].bin   = '0;
        end
        return t;
    endfunction

endpackage

// ----- sv/spectrum_top_k_peak_picker.sv -----
// ----------------------------------------------------------------------------
// Spectrum top-k peak picker: one bin accepted per cycle unless in_stall;
// the frame's NUM_PEAKS entries follow its last bin, one per cycle unless
// out_stall. Input stalls only while two finished tables wait for the output
// port. Reset clears table, counters and queue; bin_width resets to 1000.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spectrum_top_k_peak_picker
    import spk_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [WIDTH_W-1:0]        cfg_wr_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [LEVEL_W-1:0] magnitude_db,
    input  logic                      frame_end,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [RANK_W-1:0]         peak_rank,
    output logic [BIN_W-1:0]          peak_bin,
    output logic signed [LEVEL_W-1:0] peak_level,
    output logic [FREQ_W-1:0]         peak_frequency,
    output logic                      peak_valid,
    output logic                      last_peak
);

    logic [WIDTH_W-1:0] bin_width_reg;
    q_status_t          q_status;
    logic               q_push;
    logic               q_pop;
    table_t             q_push_data;
    table_t             q_pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bin_width_reg <= BIN_WIDTH_RESET;
        else if (cfg_wr_en)
            bin_width_reg <= cfg_wr_data;
    end

    spk_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .magnitude_db (magnitude_db),
        .frame_end    (frame_end),
        .q_status     (q_status),
        .q_push       (q_push),
        .q_data       (q_push_data)
    );

    spk_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_status)
    );

    spk_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .bin_width      (bin_width_reg),
        .q_status       (q_status),
        .q_data         (q_pop_data),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .peak_rank      (peak_rank),
        .peak_bin       (peak_bin),
        .peak_level     (peak_level),
        .peak_frequency (peak_frequency),
        .peak_valid     (peak_valid),
        .last_peak      (last_peak)
    );

    `ASSERT_NEVER(a_push_full, q_push && q_status.full, "table pushed into full queue")
    `ASSERT_NEVER(a_pop_empty, q_pop && q_status.empty, "table popped from empty queue")
    `ASSERT_CLK(a_frame_queued, q_push |=> !q_status.empty, "finished table not queued")

endmodule

// ----- sv/spk_front.sv -----
// ----------------------------------------------------------------------------
// Peak picker front end
// Accept bins, detect local maxima and keep the sorted table of strongest
// peaks; push the finished table on the last bin of a frame.
// ----------------------------------------------------------------------------
module spk_front
    import spk_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [LEVEL_W-1:0] magnitude_db,
    input  logic                      frame_end,
    input  q_status_t                 q_status,
    output logic                      q_push,
    output table_t                    q_data
);

    logic signed [LEVEL_W-1:0] older_reg, older_next;
    logic signed [LEVEL_W-1:0] newer_reg, newer_next;
    logic [BIN_CNT_W-1:0]      count_reg, count_next;
    table_t                    table_reg, table_next;
    table_t                    table_ins;
    logic [NUM_PEAKS-1:0]      gt;
    logic                      cand;
    logic                      accept;
    logic [BIN_CNT_W-1:0]      cand_bin;
    peak_t                     new_peak;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;
    assign cand_bin = count_reg - BIN_CNT_W'(1);

    always_comb
    begin
        cand = (count_reg >= BIN_CNT_W'(2)) && (newer_reg > older_reg)
            && (newer_reg > magnitude_db);
        new_peak.level = newer_reg;
        new_peak.bin   = BIN_W'(32'(cand_bin));
        for (int p = 0; p < NUM_PEAKS; p++)
            gt[p] = cand && (newer_reg > table_reg[p].level);
        table_ins[0] = gt[0] ? new_peak : table_reg[0];
        for (int p = 1; p < NUM_PEAKS; p++)
        begin
            if (gt[p] && !gt[p-1])
                table_ins[p] = new_peak;
            else if (gt[p])
                table_ins[p] = table_reg[p-1];
            else
                table_ins[p] = table_reg[p];
        end
    end

    always_comb
    begin
        older_next = older_reg;
        newer_next = newer_reg;
        count_next = count_reg;
        table_next = table_reg;
        q_push     = 1'b0;
        q_data     = table_ins;
        if (accept)
        begin
            if (frame_end)
            begin
                q_push     = 1'b1;
                older_next = '0;
                newer_next = '0;
                count_next = '0;
                table_next = empty_table();
            end
            else
            begin
                older_next = newer_reg;
                newer_next = magnitude_db;
                table_next = table_ins;
                if (count_reg < BIN_CNT_W'(NUM_BINS - 1))
                    count_next = count_reg + BIN_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_reg <= '0;
            newer_reg <= '0;
            count_reg <= '0;
            table_reg <= empty_table();
        end
        else
        begin
            older_reg <= older_next;
            newer_reg <= newer_next;
            count_reg <= count_next;
            table_reg <= table_next;
        end
    end

endmodule

// ----- sv/spk_queue.sv -----
// ----------------------------------------------------------------------------
// Peak table queue
// Two-entry queue of finished peak tables between front and back end.
// ----------------------------------------------------------------------------
module spk_queue
    import spk_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  table_t    push_data,
    input  logic      pop,
    output table_t    pop_data,
    output q_status_t status
);

    table_t     entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

// ----- sv/spk_back.sv -----
// ----------------------------------------------------------------------------
// Peak picker back end
// Take one finished table at a time and emit its entries in rank order
// with frequency and valid flag through an output register.
// ----------------------------------------------------------------------------
module spk_back
    import spk_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [WIDTH_W-1:0]        bin_width,
    input  q_status_t                 q_status,
    input  table_t                    q_data,
    output logic                      q_pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [RANK_W-1:0]         peak_rank,
    output logic [BIN_W-1:0]          peak_bin,
    output logic signed [LEVEL_W-1:0] peak_level,
    output logic [FREQ_W-1:0]         peak_frequency,
    output logic                      peak_valid,
    output logic                      last_peak
);

    table_t                    snap_reg;
    logic [RANK_CNT_W-1:0]     rank_reg;
    logic                      busy_reg;
    logic                      out_valid_reg;
    logic [RANK_W-1:0]         rank_out_reg;
    logic [BIN_W-1:0]          bin_out_reg;
    logic signed [LEVEL_W-1:0] level_out_reg;
    logic [FREQ_W-1:0]         freq_out_reg;
    logic                      valid_out_reg;
    logic                      last_out_reg;

    peak_t                     cur;
    logic                      out_adv;
    logic                      emit;
    logic                      last_rank;
    logic                      cur_valid;
    logic [FREQ_W-1:0]         product;

    assign cur       = snap_reg[rank_reg];
    assign out_adv   = !out_valid_reg || !out_stall;
    assign emit      = busy_reg && out_adv;
    assign last_rank = (rank_reg == RANK_CNT_W'(NUM_PEAKS - 1));
    assign q_pop     = !q_status.empty && (!busy_reg || (emit && last_rank));
    assign cur_valid = cur.level > LEVEL_VALID;
    assign product   = FREQ_W'(cur.bin) * FREQ_W'(bin_width);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rank_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                busy_reg <= 1'b1;
                rank_reg <= '0;
            end
            else if (emit)
            begin
                if (last_rank)
                    busy_reg <= 1'b0;
                else
                    rank_reg <= rank_reg + RANK_CNT_W'(1);
            end
            if (out_adv)
                out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            snap_reg <= q_data;
        if (emit)
        begin
            rank_out_reg  <= RANK_W'(rank_reg);
            bin_out_reg   <= cur.bin;
            level_out_reg <= cur.level;
            freq_out_reg  <= cur_valid ? product : '0;
            valid_out_reg <= cur_valid;
            last_out_reg  <= last_rank;
        end
    end

    assign out_valid      = out_valid_reg;
    assign peak_rank      = rank_out_reg;
    assign peak_bin       = bin_out_reg;
    assign peak_level     = level_out_reg;
    assign peak_frequency = freq_out_reg;
    assign peak_valid     = valid_out_reg;
    assign last_peak      = last_out_reg;

endmodule
